// ===== src/complex_matrix_multiply_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the complex matrix multiplier
// Implication checks on a clock with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_MATRIX_MULTIPLY_ASSERT_SVH
`define COMPLEX_MATRIX_MULTIPLY_ASSERT_SVH

// same-cycle implication
`define CMM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/cmm_pkg.sv =====
// ----------------------------------------------------------------------------
// cmm_pkg
// Shared types and constants of the complex matrix multiplier.
// ----------------------------------------------------------------------------
package cmm_pkg;

  localparam int MAX_DIM_DEF   = 8;
  localparam int ELEM_BITS_DEF = 16;
  localparam int OUT_BITS      = 37;
  localparam int DIM_W         = 4;
  localparam int IDX_W         = 3;
  localparam int OUT_TDATA_W   = ((2 * IDX_W + 2 * OUT_BITS + 7) / 8) * 8;
  localparam int CFG_AW        = 4;
  localparam int CFG_DW        = 32;

  localparam logic [1:0] FUNC_LOAD_A  = 2'd0;
  localparam logic [1:0] FUNC_LOAD_B  = 2'd1;
  localparam logic [1:0] FUNC_COMPUTE = 2'd2;

  localparam logic [1:0] REG_ROWS_A    = 2'd0;
  localparam logic [1:0] REG_INNER_DIM = 2'd1;
  localparam logic [1:0] REG_COLS_B    = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_OUT
  } cmm_state_t;

  typedef struct packed {
    logic vld;
    logic first;
    logic lastk;
  } cmm_tag_t;

  typedef struct packed {
    logic busy;
    logic fin;
  } cmm_mac_status_t;

endpackage

// ===== src/complex_matrix_multiply.sv =====
// ----------------------------------------------------------------------------
// complex_matrix_multiply
// Loads complex Q8.8 elements of A and B into two stores and streams out the
// exact complex product C = A * B in row-major order.
// ----------------------------------------------------------------------------
// Channel   Dir  Contents
// in_       in   tuser: func; tdata: row, col, re_in, im_in
// out_      out  tdata: out_row, out_col, re_out, im_out; tlast: last
// cfg_      in   APB registers rows_a (0x0), inner_dim (0x4), cols_b (0x8)
//
// A compute item yields rows_a * cols_b results, each taking one store read
// per inner step, then the three-stage multiply-accumulate pipeline drains
// before the output register. Input is accepted only between compute items;
// output stalls hold the sequencer in its output state. Reset is synchronous;
// the stores are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module complex_matrix_multiply
  import cmm_pkg::*;
#(
  parameter int MAX_DIM   = MAX_DIM_DEF,
  parameter int ELEM_BITS = ELEM_BITS_DEF,
  localparam int IN_W     = ((2 * IDX_W + 2 * ELEM_BITS + 7) / 8) * 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [IN_W-1:0]         in_tdata,   // row, col, re_in, im_in, zero pad
  input  logic [1:0]              in_tuser,   // func
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [OUT_TDATA_W-1:0]  out_tdata,  // out_row, out_col, re_out, im_out
  output logic                    out_tlast,
  input  logic                    cfg_psel,
  input  logic                    cfg_penable,
  input  logic                    cfg_pwrite,
  input  logic [CFG_AW-1:0]       cfg_paddr,
  input  logic [CFG_DW-1:0]       cfg_pwdata,
  output logic [CFG_DW-1:0]       cfg_prdata,
  output logic                    cfg_pready
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EW    = 2 * ELEM_BITS;
  localparam logic [DIM_W-1:0] DIM_MAX = (MAX_DIM > 15) ? DIM_W'(15) : DIM_W'(MAX_DIM);
  localparam logic [DIM_W-1:0] DIM_RST = (MAX_DIM > 8) ? DIM_W'(8) : DIM_MAX;

  logic [EW-1:0] mem_a [DEPTH];
  logic [EW-1:0] mem_b [DEPTH];

  cmm_state_t         st_r, st_nxt;
  logic [DIM_W-1:0]   rows_r, inner_r, cols_r;
  logic [DIM_W-1:0]   i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic               in_acc, cfg_wr, rd_en, out_load;
  logic [IDX_W-1:0]   ld_row, ld_col;
  logic               ld_ok, wr_a, wr_b;
  logic [AW-1:0]      wr_addr, a_addr, b_addr;
  logic [EW-1:0]      wr_data, a_q_r, b_q_r;
  logic [DIM_W-1:0]   cfg_val;
  cmm_tag_t           tag0, tag1_r;
  cmm_mac_status_t    mac_st;
  logic signed [OUT_BITS-1:0] acc_re, acc_im;
  logic [OUT_TDATA_W-1:0]     out_word;
  logic                       out_tvalid_r, out_tlast_r;
  logic [OUT_TDATA_W-1:0]     out_tdata_r;

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    priority if (cfg_pwdata[DIM_W-1:0] == '0) begin
      cfg_val = DIM_W'(1);
    end else if (32'(cfg_pwdata[DIM_W-1:0]) > 32'(MAX_DIM)) begin
      cfg_val = DIM_MAX;
    end else begin
      cfg_val = cfg_pwdata[DIM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= DIM_RST;
      inner_r <= DIM_RST;
      cols_r  <= DIM_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_ROWS_A:    rows_r  <= cfg_val;
        REG_INNER_DIM: inner_r <= cfg_val;
        REG_COLS_B:    cols_r  <= cfg_val;
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_ROWS_A:    cfg_prdata = CFG_DW'(rows_r);
      REG_INNER_DIM: cfg_prdata = CFG_DW'(inner_r);
      REG_COLS_B:    cfg_prdata = CFG_DW'(cols_r);
      default:       cfg_prdata = '0;
    endcase
  end

  // loads
  assign in_tready = (st_r == ST_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign ld_row    = in_tdata[IDX_W-1:0];
  assign ld_col    = in_tdata[2*IDX_W-1:IDX_W];
  assign ld_ok     = (32'(ld_row) < 32'(MAX_DIM)) && (32'(ld_col) < 32'(MAX_DIM));
  assign wr_a      = in_acc && (in_tuser == FUNC_LOAD_A) && ld_ok;
  assign wr_b      = in_acc && (in_tuser == FUNC_LOAD_B) && ld_ok;
  assign wr_addr   = AW'(32'(ld_row) * MAX_DIM + 32'(ld_col));
  assign wr_data   = in_tdata[2*IDX_W +: EW];

  assign a_addr = AW'(32'(i_r) * MAX_DIM + 32'(k_r));
  assign b_addr = AW'(32'(k_r) * MAX_DIM + 32'(j_r));

  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      a_q_r <= mem_a[a_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      mem_b[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      b_q_r <= mem_b[b_addr];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      i_r    <= '0;
      j_r    <= '0;
      k_r    <= '0;
      tag1_r <= '0;
    end else begin
      st_r   <= st_nxt;
      i_r    <= i_nxt;
      j_r    <= j_nxt;
      k_r    <= k_nxt;
      tag1_r <= tag0;
    end
  end

  always_comb begin
    st_nxt   = st_r;
    i_nxt    = i_r;
    j_nxt    = j_r;
    k_nxt    = k_r;
    rd_en    = 1'b0;
    out_load = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (in_acc && in_tuser == FUNC_COMPUTE) begin
          i_nxt  = '0;
          j_nxt  = '0;
          k_nxt  = '0;
          st_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        rd_en = 1'b1;
        if (k_r == inner_r - DIM_W'(1)) begin
          k_nxt  = '0;
          st_nxt = ST_WAIT;
        end else begin
          k_nxt = k_r + DIM_W'(1);
        end
      end
      ST_WAIT: begin
        if (mac_st.fin) begin
          st_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_load = 1'b1;
          if (j_r == cols_r - DIM_W'(1)) begin
            j_nxt = '0;
            if (i_r == rows_r - DIM_W'(1)) begin
              st_nxt = ST_IDLE;
            end else begin
              i_nxt  = i_r + DIM_W'(1);
              st_nxt = ST_ISSUE;
            end
          end else begin
            j_nxt  = j_r + DIM_W'(1);
            st_nxt = ST_ISSUE;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign tag0.vld   = rd_en;
  assign tag0.first = (k_r == '0);
  assign tag0.lastk = (k_r == inner_r - DIM_W'(1));

  cmm_mac #(
    .ELEM_BITS (ELEM_BITS)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .a_data (a_q_r),
    .b_data (b_q_r),
    .tag_in (tag1_r),
    .acc_re (acc_re),
    .acc_im (acc_im),
    .status (mac_st)
  );

  // output register
  always_comb begin
    out_word = '0;
    out_word[IDX_W-1:0]                  = i_r[IDX_W-1:0];
    out_word[2*IDX_W-1:IDX_W]            = j_r[IDX_W-1:0];
    out_word[2*IDX_W +: OUT_BITS]        = acc_re;
    out_word[2*IDX_W+OUT_BITS +: OUT_BITS] = acc_im;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= out_word;
      out_tlast_r <= (i_r == rows_r - DIM_W'(1)) && (j_r == cols_r - DIM_W'(1));
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  `include "complex_matrix_multiply_assert.svh"

  `CMM_ASSERT_NOW(a_issue_bound, clk, rst_n, st_r == ST_ISSUE, k_r < inner_r, "inner step past inner_dim")
  `CMM_ASSERT_NOW(a_out_drained, clk, rst_n, st_r == ST_OUT, !mac_st.busy && !tag1_r.vld, "pipeline busy at result")
  `CMM_ASSERT_NEXT(a_compute_start, clk, rst_n, in_acc && in_tuser == FUNC_COMPUTE, st_r == ST_ISSUE && i_r == '0 && j_r == '0 && k_r == '0, "compute did not start at origin")

endmodule

// ===== src/cmm_mac.sv =====
// ----------------------------------------------------------------------------
// cmm_mac
// Complex multiply-accumulate pipeline: products, combine, accumulate.
// ----------------------------------------------------------------------------
module cmm_mac
  import cmm_pkg::*;
#(
  parameter int ELEM_BITS = ELEM_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [2*ELEM_BITS-1:0]      a_data,
  input  logic [2*ELEM_BITS-1:0]      b_data,
  input  cmm_tag_t                    tag_in,
  output logic signed [OUT_BITS-1:0]  acc_re,
  output logic signed [OUT_BITS-1:0]  acc_im,
  output cmm_mac_status_t             status
);

  localparam int PW = 2 * ELEM_BITS;

  logic signed [ELEM_BITS-1:0] a_re, a_im, b_re, b_im;
  logic signed [PW-1:0]        p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic signed [OUT_BITS-1:0]  d_re_r, d_im_r;
  logic signed [OUT_BITS-1:0]  acc_re_r, acc_im_r;
  cmm_tag_t                    tag2_r, tag3_r;

  assign a_re = a_data[ELEM_BITS-1:0];
  assign a_im = a_data[PW-1:ELEM_BITS];
  assign b_re = b_data[ELEM_BITS-1:0];
  assign b_im = b_data[PW-1:ELEM_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag2_r <= '0;
      tag3_r <= '0;
    end else begin
      tag2_r <= tag_in;
      tag3_r <= tag2_r;
    end
  end

  always_ff @(posedge clk) begin
    p_rr_r <= a_re * b_re;
    p_ii_r <= a_im * b_im;
    p_ri_r <= a_re * b_im;
    p_ir_r <= a_im * b_re;
    d_re_r <= OUT_BITS'(p_rr_r) - OUT_BITS'(p_ii_r);
    d_im_r <= OUT_BITS'(p_ri_r) + OUT_BITS'(p_ir_r);
    if (tag3_r.vld) begin
      acc_re_r <= tag3_r.first ? d_re_r : acc_re_r + d_re_r;
      acc_im_r <= tag3_r.first ? d_im_r : acc_im_r + d_im_r;
    end
  end

  assign acc_re      = acc_re_r;
  assign acc_im      = acc_im_r;
  assign status.busy = tag2_r.vld | tag3_r.vld;
  assign status.fin  = tag3_r.vld & tag3_r.lastk;

endmodule
